@@ rtl/tcgr_pkg.sv @@
// shared types, constants and helper functions of the text cursor glyph renderer
package tcgr_pkg;

    localparam int X_W     = 13;
    localparam int Y_W     = 16;
    localparam int COLOR_W = 32;
    localparam int CODE_W  = 8;
    localparam int ADDR_W  = 11;
    localparam int BYTE_W  = 8;
    localparam int GLYPH_H = 8;
    localparam int GLYPH_W = 8;
    localparam int GLYPH_BITS = GLYPH_H * GLYPH_W;

    localparam logic           OP_LOAD = 1'b0;
    localparam logic           OP_CHAR = 1'b1;
    localparam logic [CODE_W-1:0] CODE_NL          = 8'd10;
    localparam logic [CODE_W-1:0] CODE_TAB         = 8'd9;
    localparam logic [CODE_W-1:0] CODE_FIRST_PRINT = 8'd32;

    localparam logic [X_W-1:0] WIDTH_RESET = 13'd640;
    localparam logic [X_W-1:0] X_MAX       = 13'd8191;
    localparam logic [Y_W-1:0] Y_SAT       = 16'd65528;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_DRAW,
        S_TAB
    } t_state;

    // next text row, saturating
    function automatic logic [Y_W-1:0] next_row_y(input logic [Y_W-1:0] y);
        logic [Y_W:0] s;
        s = {1'b0, y} + (Y_W+1)'(GLYPH_H);
        next_row_y = (s > {1'b0, Y_SAT}) ? Y_SAT : s[Y_W-1:0];
    endfunction

    // x advance kept at or below the largest column
    function automatic logic [X_W-1:0] sat_x(input logic [X_W:0] v);
        sat_x = v[X_W] ? X_MAX : v[X_W-1:0];
    endfunction

endpackage

@@ rtl/text_cursor_glyph_renderer.sv @@
// text console renderer: cursor, font memory and glyph pixel scan
//
//  channel | direction | handshake                     | payload
//  in      | input     | i_in_valid / o_in_stall       | op, font_addr, font_byte, char_code, color
//  out     | output    | o_out_valid / i_out_stall     | pixel_x, pixel_y, pixel_color, last
//  cfg     | input     | i_cfg_valid / o_cfg_ready     | screen_width
//
// a load word, a newline or a code that draws nothing finishes in its accept cycle
// a tab steps through quotient by reciprocal multiply, tab stop product and one correction
// a printable char reads its 8 rows through the single font read port, then scans one glyph
//   position per cycle up to the last set bit, held at a set bit while the output stalls
// output stall holds the pixel scan only at set bits; the output register lets a
//   finished char release the input while its last pixel still waits
// synchronous reset clears the cursor and control and sets the width register to 640; the font is not cleared
module text_cursor_glyph_renderer
    import tcgr_pkg::*;
#(
    parameter int FONT_BYTES = 2048,
    parameter int TAB_PIXELS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [ADDR_W-1:0]  i_font_addr,
    input  logic [BYTE_W-1:0]  i_font_byte,
    input  logic [CODE_W-1:0]  i_char_code,
    input  logic [COLOR_W-1:0] i_color,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [X_W-1:0]     o_pixel_x,
    output logic [Y_W-1:0]     o_pixel_y,
    output logic [COLOR_W-1:0] o_pixel_color,
    output logic               o_last,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [X_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(FONT_BYTES);
    localparam int MW = ADDR_W + 3;
    localparam logic [MW-1:0] Font1 = MW'(FONT_BYTES);
    localparam logic [MW-1:0] Font2 = MW'(FONT_BYTES * 2);
    localparam logic [MW-1:0] Font4 = MW'(FONT_BYTES * 4);
    localparam int PW = $clog2(GLYPH_BITS);
    localparam int CW = $clog2(X_W + 1);
    localparam int TabShift = 23;
    localparam int RCW      = 21;
    localparam logic [RCW-1:0] TabRecip = RCW'((1 << TabShift) / TAB_PIXELS);
    localparam logic [X_W-1:0] TabStep  = X_W'(TAB_PIXELS);
    localparam logic [X_W:0]   TabOne   = (X_W+1)'(TAB_PIXELS);
    localparam logic [X_W:0]   TabTwo   = (X_W+1)'(2 * TAB_PIXELS);

    // index kept below the font size: three compare-subtract steps (index < 8 x size)
    function automatic logic [AW-1:0] font_index(input logic [ADDR_W-1:0] a);
        logic [MW-1:0] v;
        v = MW'(a);
        if (v >= Font4) v = v - Font4;
        if (v >= Font2) v = v - Font2;
        if (v >= Font1) v = v - Font1;
        font_index = v[AW-1:0];
    endfunction

    t_state r_state, n_state;

    logic [X_W-1:0]        r_cur_x, n_cur_x;
    logic [Y_W-1:0]        r_cur_y, n_cur_y;
    logic [X_W-1:0]        r_width;
    logic [CODE_W-1:0]     r_code, n_code;
    logic [COLOR_W-1:0]    r_color, n_color;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [GLYPH_BITS-1:0] r_glyph, n_glyph;
    logic [PW-1:0]         r_pos, n_pos;
    logic [X_W-1:0]        r_div, n_div;

    logic                  r_out_valid, n_out_valid;
    logic [X_W-1:0]        r_px, n_px;
    logic [Y_W-1:0]        r_py, n_py;
    logic [COLOR_W-1:0]    r_pcolor, n_pcolor;
    logic                  r_plast, n_plast;

    logic                  in_accept;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [BYTE_W-1:0]     mem_rdata;

    logic                  wrap;
    logic [X_W-1:0]        wrap_x;
    logic [Y_W-1:0]        wrap_y;
    logic [X_W+RCW-1:0]    tab_prod;
    logic [X_W-1:0]        tab_rem;
    logic [X_W:0]          tab_x;
    logic                  out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pcolor;
    assign o_last        = r_plast;

    // loads and glyph reads never overlap: the block takes one item at a time
    assign mem_we    = in_accept && (i_op == OP_LOAD);
    assign mem_waddr = font_index(i_font_addr);
    assign mem_re    = (r_state == S_FETCH) && !r_cnt[CW-1];
    assign mem_raddr = font_index({r_code, r_cnt[2:0]});

    tcgr_font_mem #(
        .DEPTH (FONT_BYTES),
        .AW    (AW)
    ) u_font_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_font_byte),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign wrap   = (r_cur_x >= r_width);
    assign wrap_x = wrap ? '0 : r_cur_x;
    assign wrap_y = wrap ? next_row_y(r_cur_y) : r_cur_y;

    // quotient estimate is low by at most one, the remainder compare fixes it
    assign tab_prod = (X_W+RCW)'(r_cur_x) * (X_W+RCW)'(TabRecip);
    assign tab_rem  = r_cur_x - r_div;
    assign tab_x    = {1'b0, r_div} + ((tab_rem >= TabStep) ? TabTwo : TabOne);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_code      = r_code;
        n_color     = r_color;
        n_cnt       = r_cnt;
        n_glyph     = r_glyph;
        n_pos       = r_pos;
        n_div       = r_div;
        n_out_valid = r_out_valid && i_out_stall;
        n_px        = r_px;
        n_py        = r_py;
        n_pcolor    = r_pcolor;
        n_plast     = r_plast;

        case (r_state)
            S_IDLE: begin
                if (in_accept && (i_op == OP_CHAR)) begin
                    n_cur_x = wrap_x;
                    n_cur_y = wrap_y;
                    n_code  = i_char_code;
                    n_color = i_color;
                    n_cnt   = '0;
                    n_div   = wrap_x;
                    if (i_char_code == CODE_NL) begin
                        n_cur_x = '0;
                        n_cur_y = next_row_y(wrap_y);
                    end else if (i_char_code == CODE_TAB) begin
                        n_state = S_TAB;
                    end else if (i_char_code >= CODE_FIRST_PRINT) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                // read for row cnt goes out now, data of row cnt-1 comes back now
                n_cnt = r_cnt + 1'b1;
                if (r_cnt != '0) begin
                    n_glyph = {r_glyph[GLYPH_BITS-BYTE_W-1:0], mem_rdata};
                end
                if (r_cnt == CW'(GLYPH_H)) begin
                    n_pos   = '0;
                    n_state = S_DRAW;
                end
            end
            S_DRAW: begin
                if (r_glyph == '0) begin
                    n_cur_x = sat_x({1'b0, r_cur_x} + (X_W+1)'(GLYPH_W));
                    n_state = S_IDLE;
                end else if (!r_glyph[GLYPH_BITS-1]) begin
                    n_glyph = {r_glyph[GLYPH_BITS-2:0], 1'b0};
                    n_pos   = r_pos + 1'b1;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_px        = r_cur_x + X_W'(r_pos[2:0]);
                    n_py        = r_cur_y + Y_W'(r_pos[PW-1:3]);
                    n_pcolor    = r_color;
                    n_plast     = (r_glyph[GLYPH_BITS-2:0] == '0);
                    n_glyph     = {r_glyph[GLYPH_BITS-2:0], 1'b0};
                    n_pos       = r_pos + 1'b1;
                end
            end
            S_TAB: begin
                // quotient, then the tab stop below x, then the next stop
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '0) begin
                    n_div = X_W'(tab_prod[X_W+RCW-1:TabShift]);
                end else if (r_cnt == CW'(1)) begin
                    n_div = r_div * TabStep;
                end else begin
                    n_cur_x = sat_x(tab_x);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_width     <= WIDTH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_width <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_code   <= n_code;
        r_color  <= n_color;
        r_cnt    <= n_cnt;
        r_glyph  <= n_glyph;
        r_pos    <= n_pos;
        r_div    <= n_div;
        r_px     <= n_px;
        r_py     <= n_py;
        r_pcolor <= n_pcolor;
        r_plast  <= n_plast;
    end

endmodule

@@ rtl/tcgr_font_mem.sv @@
// font memory: one write port, one read port with registered read data
module tcgr_font_mem
    import tcgr_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tcgr_checker.sv @@
// port-level checks of the text cursor glyph renderer, bound to the top level
module tcgr_checker
    import tcgr_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_op,
    input logic [CODE_W-1:0]  i_char_code,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [X_W-1:0]     o_pixel_x,
    input logic [Y_W-1:0]     o_pixel_y,
    input logic [COLOR_W-1:0] o_pixel_color,
    input logic               o_last
);

    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // a stalled pixel word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_x)
            && $stable(o_pixel_y) && $stable(o_pixel_color) && $stable(o_last))
        else $error("stalled pixel word changed");

    // a font load finishes in its accept cycle
    a_load_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_op == OP_LOAD) |=> !o_in_stall)
        else $error("font load kept the input stalled");

    // newline and non-drawing codes finish in their accept cycle
    a_ctrl_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_op == OP_CHAR) && (i_char_code != CODE_TAB)
            && (i_char_code < CODE_FIRST_PRINT) |=> !o_in_stall)
        else $error("control code kept the input stalled");

    // pixels other than the last of a char come while the char is still in work
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !o_last |-> o_in_stall)
        else $error("input released before the last pixel of a char");

endmodule

bind text_cursor_glyph_renderer tcgr_checker u_tcgr_checker (.*);
